### sv/vpe_pkg.sv
// ----------------------------------------------------------------------------
// vpe_pkg
// Shared types, constants and character helpers for the VID/PID extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package vpe_pkg;

	localparam int CharW   = 16;
	localparam int IdW     = 16;
	localparam int NeedleN = 4;
	localparam int DigitsN = 4;
	localparam int LeadN   = 8;
	localparam int OutDataW = 40;

	typedef logic [CharW-1:0] char_t;
	typedef char_t [NeedleN-1:0] needle_t;

	localparam needle_t VidNeedle = '{16'h005F, 16'h0064, 16'h0069, 16'h0076};
	localparam needle_t PidNeedle = '{16'h005F, 16'h0064, 16'h0069, 16'h0070};
	localparam char_t   LBrace    = 16'h007B;

	typedef struct packed {
		logic           ok;
		logic [3:0]     val;
	} hex_t;

	typedef struct packed {
		logic           good;
		logic [IdW-1:0] value;
	} cap_t;

	typedef struct packed {
		logic           good;
		logic [IdW-1:0] low_half;
		logic [IdW-1:0] high_half;
	} lead_t;

	function automatic char_t fold_lower(input char_t c);
		char_t r;
		r = c;
		if (c >= 16'h0041 && c <= 16'h005A) begin
			r = c + 16'd32;
		end
		return r;
	endfunction

	function automatic hex_t hex_value(input char_t c);
		hex_t r;
		r.ok  = 1'b0;
		r.val = 4'd0;
		if (c >= 16'h0030 && c <= 16'h0039) begin
			r.ok  = 1'b1;
			r.val = 4'(c - 16'h0030);
		end else if (c >= 16'h0061 && c <= 16'h0066) begin
			r.ok  = 1'b1;
			r.val = 4'(c - 16'h0061 + 16'd10);
		end else if (c >= 16'h0041 && c <= 16'h0046) begin
			r.ok  = 1'b1;
			r.val = 4'(c - 16'h0041 + 16'd10);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### sv/usb_vid_pid_extractor_top.sv
// The result register loads as a string's last item leaves the input register.
// Throughput: one character item per cycle; input register and result register
// decouple the two sides, so only a stalled result blocks the next last item.
// Reset: arst_n clears all match state and both valid flags asynchronously.
// ----------------------------------------------------------------------------
// usb_vid_pid_extractor_top
// Extracts vendor and product identifiers from a device path string.
// ----------------------------------------------------------------------------
`default_nettype none

module usb_vid_pid_extractor_top
	import vpe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// char_code[15:0]
	input  wire logic [15:0] s_axis_tdata,
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// found, vendor_id[15:0], product_id[15:0], from_path, id_nonzero, zero pad
	output logic [OutDataW-1:0] m_axis_tdata
);

	logic  valid_s1, last_s1;
	char_t char_s1;
	logic  ended_q;
	logic  out_free, adv, step, clear;
	cap_t  vid_cap, pid_cap;
	lead_t lead;

	assign adv           = valid_s1 && (!last_s1 || out_free);
	assign step          = adv && !ended_q && (char_s1 != '0);
	assign clear         = adv && last_s1;
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ended_q <= 1'b0;
		end else if (clear) begin
			ended_q <= 1'b0;
		end else if (adv && char_s1 == '0) begin
			ended_q <= 1'b1;
		end
	end

	vpe_field u_vid (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.clear     (clear),
		.char_code (char_s1),
		.needle    (VidNeedle),
		.cap       (vid_cap)
	);

	vpe_field u_pid (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.clear     (clear),
		.char_code (char_s1),
		.needle    (PidNeedle),
		.cap       (pid_cap)
	);

	vpe_lead u_lead (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.clear     (clear),
		.char_code (char_s1),
		.lead      (lead)
	);

	vpe_result u_result (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (clear),
		.vid           (vid_cap),
		.pid           (pid_cap),
		.lead          (lead),
		.free          (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	a_nonzero_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[34] |-> m_axis_tdata[0])
		else $error("id_nonzero without found");

	a_path_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[33] |-> m_axis_tdata[0])
		else $error("from_path without found");

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[32:1] == 32'd0)
		else $error("identifiers nonzero when not found");

	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && m_axis_tvalid && !m_axis_tready |=> valid_s1 && last_s1)
		else $error("last item dropped while result stalled");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stalled with empty stage");

endmodule

`default_nettype wire

### sv/vpe_field.sv
// ----------------------------------------------------------------------------
// vpe_field
// Finds the first case-insensitive needle match and captures four hex digits.
// ----------------------------------------------------------------------------
`default_nettype none

module vpe_field
	import vpe_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    step,
	input  wire logic    clear,
	input  wire char_t   char_code,
	input  wire needle_t needle,
	output cap_t         cap
);

	logic [2:0]     match_pos_q, match_pos_d;
	logic           seen_q, seen_d;
	logic [2:0]     count_q, count_d;
	logic [IdW-1:0] accum_q, accum_d;
	logic           bad_q, bad_d;
	char_t          low;
	hex_t           hx;

	always_comb begin
		low         = fold_lower(char_code);
		hx          = hex_value(char_code);
		match_pos_d = match_pos_q;
		seen_d      = seen_q;
		count_d     = count_q;
		accum_d     = accum_q;
		bad_d       = bad_q;
		if (step) begin
			if (seen_q) begin
				if (count_q < 3'(DigitsN)) begin
					if (!hx.ok) begin
						bad_d = 1'b1;
					end else begin
						accum_d = {accum_q[IdW-5:0], hx.val};
					end
					count_d = count_q + 3'd1;
				end
			end else begin
				if (low == needle[match_pos_q[1:0]]) begin
					match_pos_d = match_pos_q + 3'd1;
				end else begin
					match_pos_d = (low == needle[0]) ? 3'd1 : 3'd0;
				end
				if (match_pos_d >= 3'(NeedleN)) begin
					seen_d      = 1'b1;
					match_pos_d = 3'(NeedleN);
				end
			end
		end
		cap.good  = seen_d && (count_d >= 3'(DigitsN)) && !bad_d;
		cap.value = accum_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_pos_q <= '0;
			seen_q      <= 1'b0;
			count_q     <= '0;
			accum_q     <= '0;
			bad_q       <= 1'b0;
		end else if (clear) begin
			match_pos_q <= '0;
			seen_q      <= 1'b0;
			count_q     <= '0;
			accum_q     <= '0;
			bad_q       <= 1'b0;
		end else begin
			match_pos_q <= match_pos_d;
			seen_q      <= seen_d;
			count_q     <= count_d;
			accum_q     <= accum_d;
			bad_q       <= bad_d;
		end
	end

endmodule

`default_nettype wire

### sv/vpe_lead.sv
// ----------------------------------------------------------------------------
// vpe_lead
// Captures eight hex digits at the string start, skipping one leading brace.
// ----------------------------------------------------------------------------
`default_nettype none

module vpe_lead
	import vpe_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  step,
	input  wire logic  clear,
	input  wire char_t char_code,
	output lead_t      lead
);

	logic [3:0]       pos_q, pos_d;
	logic             started_q, started_d;
	logic [2*IdW-1:0] accum_q, accum_d;
	logic             bad_q, bad_d;
	hex_t             hx;
	logic             skip;

	always_comb begin
		hx        = hex_value(char_code);
		pos_d     = pos_q;
		started_d = started_q;
		accum_d   = accum_q;
		bad_d     = bad_q;
		skip      = 1'b0;
		if (step) begin
			if (!started_q) begin
				started_d = 1'b1;
				skip      = (char_code == LBrace);
			end
			if (!skip && pos_q < 4'(LeadN)) begin
				if (!hx.ok) begin
					bad_d = 1'b1;
				end else begin
					accum_d = {accum_q[2*IdW-5:0], hx.val};
				end
				pos_d = pos_q + 4'd1;
			end
		end
		lead.good      = (pos_d >= 4'(LeadN)) && !bad_d;
		lead.low_half  = accum_d[IdW-1:0];
		lead.high_half = accum_d[2*IdW-1:IdW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			started_q <= 1'b0;
			accum_q   <= '0;
			bad_q     <= 1'b0;
		end else if (clear) begin
			pos_q     <= '0;
			started_q <= 1'b0;
			accum_q   <= '0;
			bad_q     <= 1'b0;
		end else begin
			pos_q     <= pos_d;
			started_q <= started_d;
			accum_q   <= accum_d;
			bad_q     <= bad_d;
		end
	end

endmodule

`default_nettype wire

### sv/vpe_result.sv
// ----------------------------------------------------------------------------
// vpe_result
// Selects primary or fallback identifiers and holds the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module vpe_result
	import vpe_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  load,
	input  wire cap_t  vid,
	input  wire cap_t  pid,
	input  wire lead_t lead,
	output logic       free,
	output logic       m_axis_tvalid,
	input  wire logic  m_axis_tready,
	// found, vendor_id[15:0], product_id[15:0], from_path, id_nonzero, zero pad
	output logic [OutDataW-1:0] m_axis_tdata
);

	logic           valid_q;
	logic           found_q, from_path_q, nonzero_q;
	logic [IdW-1:0] vendor_q, product_q;
	logic           found, from_path;
	logic [IdW-1:0] vendor, product;

	always_comb begin
		found     = 1'b0;
		from_path = 1'b0;
		vendor    = '0;
		product   = '0;
		if (vid.good && pid.good) begin
			found     = 1'b1;
			from_path = 1'b1;
			vendor    = vid.value;
			product   = pid.value;
		end else if (lead.good) begin
			found   = 1'b1;
			vendor  = lead.low_half;
			product = lead.high_half;
		end
	end

	assign free = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			found_q     <= found;
			from_path_q <= from_path;
			vendor_q    <= vendor;
			product_q   <= product;
			nonzero_q   <= found && ((vendor | product) != '0);
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {5'd0, nonzero_q, from_path_q, product_q, vendor_q, found_q};

endmodule

`default_nettype wire
